@@ rtl/bfaa_pkg.sv @@
package bfaa_pkg;

  // Widths fixed by the item fields.
  localparam int BYTES_W = 13;
  localparam int UNIT_W  = 8;
  localparam int FREE_W  = 9;

  // Byte count plus rounding term fits 14 bits for any unit size up to 64.
  localparam int X_W = 14;
  // Unit count of the largest request at the smallest unit size.
  localparam int NEED_W = 12;
  // Shift of the reciprocal used for the divide by the unit size.
  localparam int RECIP_SHIFT = 20;
  // A remainder below this many units is not split off.
  localparam int MIN_REMAIN = 3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_DIV,
    OP_AW_START,
    OP_AW_STEP,
    OP_A_WHOLE,
    OP_A_CARVE1,
    OP_A_CARVE2,
    OP_F_START,
    OP_F_STEP,
    OP_F_CHK,
    OP_F_NEXT,
    OP_F_PREV
  } op_e;

  typedef struct packed {
    op_e     op;
    logic    res_load;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic bytes_zero;
    logic free_bad;
    logic unit_one;
    logic too_big;
    logic gt_free;
    logic walk_end;
    logic fw_found;
    logic fw_miss;
    logic best_none;
    logic whole;
    logic hdr_free;
  } stat_t;

endpackage

@@ rtl/bfaa_ctrl.sv @@
module bfaa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bfaa_pkg::stat_t  stat_i,
  output bfaa_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ACHK,
    S_AWALK,
    S_ASEL,
    S_ASPL,
    S_FWALK,
    S_FCHK,
    S_FNXT,
    S_FPRV
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d            = state_q;
    cmd_o.op           = bfaa_pkg::OP_NONE;
    cmd_o.res_load     = 1'b0;
    cmd_o.res_status   = bfaa_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (!stat_i.req_free) begin
            if (stat_i.bytes_zero) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = bfaa_pkg::ST_BAD_SIZE;
            end else begin
              cmd_o.op = bfaa_pkg::OP_LOAD;
              state_d  = S_MUL;
            end
          end else if (stat_i.free_bad) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = bfaa_pkg::ST_BAD_FREE;
          end else begin
            // The first chunk sits at unit zero, so it needs no walk.
            cmd_o.op = bfaa_pkg::OP_F_START;
            state_d  = stat_i.unit_one ? S_FCHK : S_FWALK;
          end
        end
      end
      S_MUL: begin
        cmd_o.op = bfaa_pkg::OP_MUL;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = bfaa_pkg::OP_DIV;
        state_d  = S_ACHK;
      end
      S_ACHK: begin
        if (stat_i.too_big) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bfaa_pkg::ST_BAD_SIZE;
          state_d          = S_IDLE;
        end else if (stat_i.gt_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bfaa_pkg::ST_NO_FIT;
          state_d          = S_IDLE;
        end else begin
          cmd_o.op = bfaa_pkg::OP_AW_START;
          state_d  = S_AWALK;
        end
      end
      S_AWALK: begin
        cmd_o.op = bfaa_pkg::OP_AW_STEP;
        if (stat_i.walk_end) begin
          state_d = S_ASEL;
        end
      end
      S_ASEL: begin
        if (stat_i.best_none) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bfaa_pkg::ST_NO_FIT;
          state_d          = S_IDLE;
        end else if (stat_i.whole) begin
          cmd_o.op         = bfaa_pkg::OP_A_WHOLE;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bfaa_pkg::ST_OK;
          state_d          = S_IDLE;
        end else begin
          cmd_o.op = bfaa_pkg::OP_A_CARVE1;
          state_d  = S_ASPL;
        end
      end
      S_ASPL: begin
        cmd_o.op         = bfaa_pkg::OP_A_CARVE2;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = bfaa_pkg::ST_OK;
        state_d          = S_IDLE;
      end
      S_FWALK: begin
        cmd_o.op = bfaa_pkg::OP_F_STEP;
        if (stat_i.fw_found) begin
          state_d = S_FCHK;
        end else if (stat_i.fw_miss) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bfaa_pkg::ST_BAD_FREE;
          state_d          = S_IDLE;
        end
      end
      S_FCHK: begin
        if (stat_i.hdr_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bfaa_pkg::ST_BAD_FREE;
          state_d          = S_IDLE;
        end else begin
          cmd_o.op = bfaa_pkg::OP_F_CHK;
          state_d  = S_FNXT;
        end
      end
      S_FNXT: begin
        cmd_o.op = bfaa_pkg::OP_F_NEXT;
        state_d  = S_FPRV;
      end
      S_FPRV: begin
        cmd_o.op         = bfaa_pkg::OP_F_PREV;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = bfaa_pkg::ST_OK;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ rtl/bfaa_datapath.sv @@
module bfaa_datapath #(
  parameter int ARENA_UNITS = 256,
  parameter int UNIT_BYTES  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            action_i,
  input  logic [bfaa_pkg::BYTES_W-1:0]    request_bytes_i,
  input  logic [bfaa_pkg::UNIT_W-1:0]     payload_unit_i,
  input  bfaa_pkg::cmd_t                  cmd_i,
  output bfaa_pkg::stat_t                 stat_o,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [bfaa_pkg::UNIT_W-1:0]     granted_unit_o,
  output logic [bfaa_pkg::FREE_W-1:0]     free_units_o
);

  localparam int AW = $clog2(ARENA_UNITS);
  localparam int LW = AW + 1;
  localparam int CW = (LW > bfaa_pkg::NEED_W) ? LW : bfaa_pkg::NEED_W;
  localparam int WW = (LW > bfaa_pkg::UNIT_W) ? LW : bfaa_pkg::UNIT_W;
  localparam int FW = (LW > bfaa_pkg::FREE_W) ? LW : bfaa_pkg::FREE_W;
  localparam int RECIP = (1 << bfaa_pkg::RECIP_SHIFT) / UNIT_BYTES;
  localparam int RW = $clog2(RECIP + 1);
  localparam int PW = bfaa_pkg::X_W + RW;
  localparam logic [LW-1:0] END = LW'(ARENA_UNITS);

  // Chunk headers. Header zero lives in flops so that reset sets it up.
  logic [LW-1:0] next_mem [ARENA_UNITS];
  logic [LW-1:0] prev_mem [ARENA_UNITS];
  logic          free_mem [ARENA_UNITS];

  logic          next_we, prev_we, free_we;
  logic [AW-1:0] next_wa, prev_wa, free_wa;
  logic [LW-1:0] next_wd, prev_wd;
  logic          free_wd;
  logic [AW-1:0] rd_addr;

  logic [LW-1:0] rd_next_q, rd_prev_q;
  logic          rd_free_q;
  logic          rd_zero_q;
  logic [LW-1:0] next0_q, next0_d;
  logic          free0_q, free0_d;

  logic [LW-1:0] hdr_next, hdr_prev;
  logic          hdr_free;

  logic [bfaa_pkg::X_W-1:0]    x_q, x_d;
  logic [PW-1:0]               prod_q, prod_d;
  logic [bfaa_pkg::NEED_W-1:0] need_q, need_d;
  logic [LW-1:0]               cur_q, cur_d;
  logic [LW-1:0]               best_q, best_d;
  logic [LW-1:0]               bsize_q, bsize_d;
  logic [AW-1:0]               g_q, g_d;
  logic [LW-1:0]               nx_q, nx_d;
  logic [AW-1:0]               ct_q, ct_d;
  logic [LW-1:0]               n_q, n_d;
  logic [LW-1:0]               p_q, p_d;
  logic [LW-1:0]               cn_q, cn_d;
  logic [LW-1:0]               fc_q, fc_d;
  logic [1:0]                  status_q, status_d;
  logic [bfaa_pkg::UNIT_W-1:0] granted_q, granted_d;
  logic                        done_q;

  logic [LW-1:0]               need_l, ct_ext;
  logic [LW-1:0]               walk_n, walk_sz, chk_n, nn;
  logic [LW-1:0]               sel_nx, sel_rem, carve_g;
  logic [bfaa_pkg::NEED_W-1:0] q0;
  logic [bfaa_pkg::X_W-1:0]    qm, rem_x;
  logic [LW-1:0]               grant_sel, grant_sum;
  logic                        grant_hit;
  logic [WW-1:0]               grant_ext;
  logic [FW-1:0]               fc_ext;

  // Next chunk after c, forced forward and inside the arena.
  function automatic logic [LW-1:0] link_after(input logic [LW-1:0] c,
                                               input logic [LW-1:0] n);
    return ((n <= c) || (n > END)) ? END : n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    rd_next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    rd_prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    rd_free_q <= free_mem[rd_addr];
  end

  // The first chunk never gains a predecessor.
  assign hdr_next = rd_zero_q ? next0_q : rd_next_q;
  assign hdr_prev = rd_zero_q ? END : rd_prev_q;
  assign hdr_free = rd_zero_q ? free0_q : rd_free_q;

  assign need_l  = LW'(need_q);
  assign ct_ext  = LW'(ct_q);
  assign walk_n  = link_after(cur_q, hdr_next);
  assign walk_sz = walk_n - cur_q;
  assign chk_n   = link_after(ct_ext, hdr_next);
  assign nn      = link_after(n_q, hdr_next);
  assign sel_nx  = best_q + bsize_q;
  assign sel_rem = bsize_q - need_l;
  assign carve_g = sel_nx - need_l;

  // Divide by the unit size: reciprocal estimate is low by at most one.
  assign q0    = bfaa_pkg::NEED_W'(prod_q >> bfaa_pkg::RECIP_SHIFT);
  assign qm    = bfaa_pkg::X_W'(q0 * UNIT_BYTES);
  assign rem_x = x_q - qm;

  always_comb begin
    stat_o.req_free   = (action_i == bfaa_pkg::ACT_FREE);
    stat_o.bytes_zero = (request_bytes_i == '0);
    stat_o.free_bad   = (payload_unit_i == '0) ||
                        (WW'(payload_unit_i) >= WW'(ARENA_UNITS));
    stat_o.unit_one   = (payload_unit_i == bfaa_pkg::UNIT_W'(1));
    stat_o.too_big    = (CW'(need_q) > CW'(ARENA_UNITS));
    stat_o.gt_free    = (CW'(need_q) > CW'(fc_q));
    stat_o.walk_end   = (walk_n == END);
    stat_o.fw_found   = (walk_n == ct_ext);
    stat_o.fw_miss    = (walk_n > ct_ext);
    stat_o.best_none  = (best_q == END);
    stat_o.whole      = (sel_rem < LW'(bfaa_pkg::MIN_REMAIN));
    stat_o.hdr_free   = hdr_free;
  end

  always_comb begin
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    free_we = 1'b0;
    free_wa = '0;
    free_wd = 1'b0;
    rd_addr = '0;
    x_d     = x_q;
    prod_d  = prod_q;
    need_d  = need_q;
    cur_d   = cur_q;
    best_d  = best_q;
    bsize_d = bsize_q;
    g_d     = g_q;
    nx_d    = nx_q;
    ct_d    = ct_q;
    n_d     = n_q;
    p_d     = p_q;
    cn_d    = cn_q;
    fc_d    = fc_q;
    case (cmd_i.op)
      bfaa_pkg::OP_LOAD: begin
        x_d = bfaa_pkg::X_W'(request_bytes_i) + bfaa_pkg::X_W'(2 * UNIT_BYTES - 1);
      end
      bfaa_pkg::OP_MUL: begin
        prod_d = PW'(x_q) * PW'(RECIP);
      end
      bfaa_pkg::OP_DIV: begin
        need_d = (rem_x >= bfaa_pkg::X_W'(UNIT_BYTES)) ?
                 q0 + bfaa_pkg::NEED_W'(1) : q0;
      end
      bfaa_pkg::OP_AW_START: begin
        cur_d   = '0;
        best_d  = END;
        bsize_d = '0;
        rd_addr = '0;
      end
      bfaa_pkg::OP_AW_STEP: begin
        // Strictly smaller wins, so the first of equal sizes is kept.
        if (hdr_free && (walk_sz >= need_l) &&
            ((best_q == END) || (walk_sz < bsize_q))) begin
          best_d  = cur_q;
          bsize_d = walk_sz;
        end
        cur_d   = walk_n;
        rd_addr = AW'(walk_n);
      end
      bfaa_pkg::OP_A_WHOLE: begin
        free_we = 1'b1;
        free_wa = AW'(best_q);
        free_wd = 1'b0;
        fc_d    = fc_q - bsize_q;
      end
      bfaa_pkg::OP_A_CARVE1: begin
        next_we = 1'b1;
        next_wa = AW'(carve_g);
        next_wd = sel_nx;
        prev_we = 1'b1;
        prev_wa = AW'(carve_g);
        prev_wd = best_q;
        free_we = 1'b1;
        free_wa = AW'(carve_g);
        free_wd = 1'b0;
        g_d     = AW'(carve_g);
        nx_d    = sel_nx;
      end
      bfaa_pkg::OP_A_CARVE2: begin
        next_we = 1'b1;
        next_wa = AW'(best_q);
        next_wd = LW'(g_q);
        prev_we = (nx_q != END);
        prev_wa = AW'(nx_q);
        prev_wd = LW'(g_q);
        fc_d    = fc_q - need_l;
      end
      bfaa_pkg::OP_F_START: begin
        ct_d    = AW'(WW'(payload_unit_i) - WW'(1));
        cur_d   = '0;
        rd_addr = '0;
      end
      bfaa_pkg::OP_F_STEP: begin
        cur_d   = walk_n;
        rd_addr = AW'(walk_n);
      end
      bfaa_pkg::OP_F_CHK: begin
        free_we = 1'b1;
        free_wa = ct_q;
        free_wd = 1'b1;
        n_d     = chk_n;
        p_d     = hdr_prev;
        fc_d    = fc_q + (chk_n - ct_ext);
        rd_addr = AW'(chk_n);
      end
      bfaa_pkg::OP_F_NEXT: begin
        if ((n_q != END) && hdr_free) begin
          next_we = 1'b1;
          next_wa = ct_q;
          next_wd = nn;
          prev_we = (nn != END);
          prev_wa = AW'(nn);
          prev_wd = ct_ext;
          cn_d    = nn;
        end else begin
          cn_d = n_q;
        end
        rd_addr = AW'(p_q);
      end
      bfaa_pkg::OP_F_PREV: begin
        if ((p_q < ct_ext) && hdr_free) begin
          next_we = 1'b1;
          next_wa = AW'(p_q);
          next_wd = cn_q;
          prev_we = (cn_q != END);
          prev_wa = AW'(cn_q);
          prev_wd = p_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    next0_d = next0_q;
    free0_d = free0_q;
    if (next_we && (next_wa == '0)) begin
      next0_d = next_wd;
    end
    if (free_we && (free_wa == '0)) begin
      free0_d = free_wd;
    end
  end

  always_comb begin
    grant_hit = 1'b0;
    grant_sel = '0;
    case (cmd_i.op)
      bfaa_pkg::OP_A_WHOLE: begin
        grant_hit = 1'b1;
        grant_sel = best_q;
      end
      bfaa_pkg::OP_A_CARVE2: begin
        grant_hit = 1'b1;
        grant_sel = LW'(g_q);
      end
      default: begin
      end
    endcase
  end

  assign grant_sum = grant_sel + LW'(1);
  assign grant_ext = WW'(grant_sum);

  always_comb begin
    status_d  = status_q;
    granted_d = granted_q;
    if (cmd_i.res_load) begin
      status_d  = cmd_i.res_status;
      granted_d = grant_hit ? grant_ext[bfaa_pkg::UNIT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next0_q <= END;
      free0_q <= 1'b1;
      fc_q    <= END;
      done_q  <= 1'b0;
    end else begin
      next0_q <= next0_d;
      free0_q <= free0_d;
      fc_q    <= fc_d;
      done_q  <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_zero_q <= (rd_addr == '0);
    x_q       <= x_d;
    prod_q    <= prod_d;
    need_q    <= need_d;
    cur_q     <= cur_d;
    best_q    <= best_d;
    bsize_q   <= bsize_d;
    g_q       <= g_d;
    nx_q      <= nx_d;
    ct_q      <= ct_d;
    n_q       <= n_d;
    p_q       <= p_d;
    cn_q      <= cn_d;
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  assign fc_ext         = FW'(fc_q);
  assign free_units_o   = fc_ext[bfaa_pkg::FREE_W-1:0];
  assign status_o       = status_q;
  assign granted_unit_o = granted_q;
  assign done_o         = done_q;

endmodule

@@ rtl/best_fit_arena_allocator_unit.sv @@
// Flow: a zero-byte allocate or a free outside the arena strobes done in the cycle after
// start; a too-large or over-budget allocate strobes after the load, multiply, divide and check
// steps. A walked allocate reads each chunk header, one header a cycle, then selects and may split;
// a free walks the chunks ahead of the freed one, then checks it and merges it with free neighbours.
// Throughput: one item at a time; start is taken again in the cycle done strobes.
// The receiver cannot stall. Reset clears the controller and sets up one free chunk.
module best_fit_arena_allocator_unit #(
  parameter int ARENA_UNITS = 256,
  parameter int UNIT_BYTES  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            action_i,
  input  logic [bfaa_pkg::BYTES_W-1:0]    request_bytes_i,
  input  logic [bfaa_pkg::UNIT_W-1:0]     payload_unit_i,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [bfaa_pkg::UNIT_W-1:0]     granted_unit_o,
  output logic [bfaa_pkg::FREE_W-1:0]     free_units_o
);

  bfaa_pkg::cmd_t  cmd;
  bfaa_pkg::stat_t stat;

  bfaa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  bfaa_datapath #(
    .ARENA_UNITS (ARENA_UNITS),
    .UNIT_BYTES  (UNIT_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .request_bytes_i (request_bytes_i),
    .payload_unit_i  (payload_unit_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_unit_o  (granted_unit_o),
    .free_units_o    (free_units_o)
  );

endmodule

@@ rtl/bfaa_checker.sv @@
module bfaa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            action_i,
  input logic [bfaa_pkg::BYTES_W-1:0]    request_bytes_i,
  input logic [bfaa_pkg::UNIT_W-1:0]     payload_unit_i,
  input logic                            done_o,
  input logic [1:0]                      status_o,
  input logic [bfaa_pkg::UNIT_W-1:0]     granted_unit_o
);

  // A result always comes back with the block ready for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without an accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i == bfaa_pkg::ACT_ALLOC) &&
     (request_bytes_i == '0))
    |=> (done_o && (status_o == bfaa_pkg::ST_BAD_SIZE)))
    else $error("zero-byte allocate not rejected at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i == bfaa_pkg::ACT_FREE) &&
     (payload_unit_i == '0))
    |=> (done_o && (status_o == bfaa_pkg::ST_BAD_FREE)))
    else $error("free of unit zero not rejected at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != bfaa_pkg::ST_OK)) |-> (granted_unit_o == '0))
    else $error("granted unit nonzero on a failed item");

endmodule

bind best_fit_arena_allocator_unit bfaa_checker u_bfaa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .action_i        (action_i),
  .request_bytes_i (request_bytes_i),
  .payload_unit_i  (payload_unit_i),
  .done_o          (done_o),
  .status_o        (status_o),
  .granted_unit_o  (granted_unit_o)
);

@@ tb/arena_grant_checker.sv @@
`timescale 1ns / 1ps

module arena_grant_checker
  import bfaa_pkg::*;
#(
  parameter int ARENA_UNITS = 256,
  parameter int UNIT_BYTES  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               action_i,
  input  logic [BYTES_W-1:0] request_bytes_i,
  input  logic [UNIT_W-1:0]  payload_unit_i,
  input  logic               done_i,
  input  logic [1:0]         status_i,
  input  logic [UNIT_W-1:0]  granted_unit_i,
  input  logic [FREE_W-1:0]  free_units_i,
  output int                 mismatches_o,
  output int                 pending_o
);

  typedef struct packed {
    status_e             status;
    logic [UNIT_W-1:0]   unit;
    logic [FREE_W-1:0]   free_units;
  } reply_t;

  // Shadow copy of the chunk headers; ARENA_UNITS marks the end of the arena.
  int     next_hdr [ARENA_UNITS];
  int     prev_hdr [ARENA_UNITS];
  bit     hdr_free [ARENA_UNITS];
  int     units_free;
  reply_t awaited_replies[$];
  reply_t oldest;
  reply_t fresh;

  initial begin
    for (int i = 0; i < ARENA_UNITS; i++) begin
      next_hdr[i] = 0;
      prev_hdr[i] = 0;
      hdr_free[i] = 1'b0;
    end
    next_hdr[0]  = ARENA_UNITS;
    prev_hdr[0]  = ARENA_UNITS;
    hdr_free[0]  = 1'b1;
    units_free   = ARENA_UNITS;
    mismatches_o = 0;
    pending_o    = 0;
  end

  // A link that does not move forward is treated as the end of the arena.
  function automatic int hop(int c);
    int n;
    n = next_hdr[c];
    if (n <= c || n > ARENA_UNITS) return ARENA_UNITS;
    return n;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic grant_request(input int nbytes, output reply_t r);
    int need, c, n, sz, best, best_sz, steps, g, nx;
    r.status = ST_OK;
    r.unit   = '0;
    need = (nbytes + 2 * UNIT_BYTES - 1) / UNIT_BYTES;
    if (nbytes == 0 || need > ARENA_UNITS) begin
      r.status = ST_BAD_SIZE;
    end else if (need > units_free) begin
      r.status = ST_NO_FIT;
    end else begin
      best    = ARENA_UNITS;
      best_sz = 0;
      c       = 0;
      steps   = 0;
      // Smallest free chunk that fits; the first one wins a tie.
      while (c < ARENA_UNITS && steps < ARENA_UNITS) begin
        n  = hop(c);
        sz = n - c;
        if (hdr_free[c] && sz >= need && (best == ARENA_UNITS || sz < best_sz)) begin
          best    = c;
          best_sz = sz;
        end
        c = n;
        steps++;
      end
      if (best == ARENA_UNITS) begin
        r.status = ST_NO_FIT;
      end else begin
        nx = hop(best);
        if (best_sz - need < MIN_REMAIN) begin
          g = best;
          units_free -= best_sz;
        end else begin
          // Carve the request from the top end of the chunk.
          g = nx - need;
          next_hdr[g] = nx;
          prev_hdr[g] = best;
          if (nx != ARENA_UNITS) prev_hdr[nx] = g;
          next_hdr[best] = g;
          units_free -= need;
        end
        hdr_free[g] = 1'b0;
        r.unit = UNIT_W'(g + 1);
      end
    end
    r.free_units = FREE_W'(units_free);
  endtask

  task automatic release_request(input int unit, output reply_t r);
    int c, w, steps, n, nn, p, cn;
    bit found;
    r.status = ST_OK;
    r.unit   = '0;
    found    = 1'b0;
    c        = unit - 1;
    w        = 0;
    steps    = 0;
    if (unit != 0 && unit < ARENA_UNITS) begin
      while (w < ARENA_UNITS && steps < ARENA_UNITS) begin
        if (w == c) begin
          found = 1'b1;
          break;
        end
        if (w > c) break;
        w = hop(w);
        steps++;
      end
    end
    if (!found || hdr_free[c]) begin
      r.status = ST_BAD_FREE;
    end else begin
      hdr_free[c] = 1'b1;
      n = hop(c);
      units_free += n - c;
      if (n != ARENA_UNITS && hdr_free[n]) begin
        nn = hop(n);
        next_hdr[c] = nn;
        if (nn != ARENA_UNITS) prev_hdr[nn] = c;
      end
      p = prev_hdr[c];
      if (p < c && hdr_free[p]) begin
        cn = hop(c);
        next_hdr[p] = cn;
        if (cn != ARENA_UNITS) prev_hdr[cn] = p;
      end
    end
    r.free_units = FREE_W'(units_free);
  endtask

  // Results are matched before the item taken at the same edge is queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_i === 1'b1) begin
        if (awaited_replies.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: status %0d unit %0d free %0d",
                                  status_i, granted_unit_i, free_units_i));
        end else begin
          oldest = awaited_replies.pop_front();
          if (status_i !== oldest.status)
            note_mismatch($sformatf("status %0d, expected %0d", status_i, oldest.status));
          if (granted_unit_i !== oldest.unit)
            note_mismatch($sformatf("granted unit %0d, expected %0d",
                                    granted_unit_i, oldest.unit));
          if (free_units_i !== oldest.free_units)
            note_mismatch($sformatf("free units %0d, expected %0d",
                                    free_units_i, oldest.free_units));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        if (action_i == ACT_ALLOC) grant_request(int'(request_bytes_i), fresh);
        else release_request(int'(payload_unit_i), fresh);
        awaited_replies.push_back(fresh);
      end
      pending_o = awaited_replies.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bfaa_pkg::*;

  localparam int ARENA_UNITS = 256;
  localparam int UNIT_BYTES  = 16;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               action;
  logic [BYTES_W-1:0] request_bytes;
  logic [UNIT_W-1:0]  payload_unit;
  logic               done;
  logic [1:0]         status;
  logic [UNIT_W-1:0]  granted;
  logic [FREE_W-1:0]  free_units;
  int                 mismatches;
  int                 pending;
  int                 idle_pct;
  int                 live_units[$];
  int                 retired_units[$];

  always #10 clk = ~clk;

  best_fit_arena_allocator_unit #(
    .ARENA_UNITS(ARENA_UNITS),
    .UNIT_BYTES (UNIT_BYTES)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .action_i       (action),
    .request_bytes_i(request_bytes),
    .payload_unit_i (payload_unit),
    .done_o         (done),
    .status_o       (status),
    .granted_unit_o (granted),
    .free_units_o   (free_units)
  );

  arena_grant_checker #(
    .ARENA_UNITS(ARENA_UNITS),
    .UNIT_BYTES (UNIT_BYTES)
  ) checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .action_i       (action),
    .request_bytes_i(request_bytes),
    .payload_unit_i (payload_unit),
    .done_i         (done),
    .status_i       (status),
    .granted_unit_i (granted),
    .free_units_i   (free_units),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Granted payloads become candidates for later well-formed frees.
  always @(posedge clk) begin
    if (rst_n && done === 1'b1 && status == ST_OK && granted != '0)
      live_units.push_back(int'(granted));
  end

  task automatic issue(input logic act, input int nbytes, input int unit);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    action        = act;
    request_bytes = nbytes[BYTES_W-1:0];
    payload_unit  = unit[UNIT_W-1:0];
    start         = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic request_alloc(input int nbytes);
    issue(ACT_ALLOC, nbytes, $urandom_range(255));
  endtask

  task automatic request_free(input int unit);
    issue(ACT_FREE, $urandom_range(4096), unit);
  endtask

  // Holds off the next item until every result is back.
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_item;
    int pick, alloc_share, idx, nbytes, unit;
    alloc_share = (live_units.size() > 24) ? 35 : 55;
    pick = $urandom_range(99);
    if (live_units.size() == 0 || pick < alloc_share) begin
      pick = $urandom_range(99);
      if (pick < 70) nbytes = $urandom_range(64, 1);
      else if (pick < 90) nbytes = $urandom_range(512, 65);
      else if (pick < 97) nbytes = $urandom_range(2048, 513);
      else if (pick == 97) nbytes = 0;
      else if (pick == 98) nbytes = 4096;
      else nbytes = $urandom_range(4096);
      request_alloc(nbytes);
    end else if (pick < 90) begin
      idx  = $urandom_range(live_units.size() - 1);
      unit = live_units[idx];
      live_units.delete(idx);
      retired_units.push_back(unit);
      if (retired_units.size() > 8) void'(retired_units.pop_front());
      request_free(unit);
    end else if (pick < 95 || retired_units.size() == 0) begin
      request_free($urandom_range(255));
    end else begin
      request_free(retired_units[$urandom_range(retired_units.size() - 1)]);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    action        = ACT_ALLOC;
    request_bytes = '0;
    payload_unit  = '0;
    idle_pct      = 25;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Size limits, whole-arena grant, rejected and repeated frees.
    request_alloc(0);
    request_alloc(4096);
    request_alloc(4080);
    request_free(0);
    request_free(1);
    request_free(1);
    // Carving from the top, then a grant that leaves too small a remainder.
    request_alloc(1);
    request_alloc(16);
    request_alloc(17);
    request_alloc(3952);
    // Frees that merge with nothing, the previous chunk, or the following chunk.
    request_free(253);
    request_free(255);
    request_free(250);
    request_free(1);
    // Two equal free holes: the first one wins; then enough free units but no hole.
    request_alloc(32);
    request_alloc(32);
    request_alloc(32);
    request_alloc(32);
    request_free(254);
    request_free(248);
    request_alloc(1);
    request_alloc(3905);
    request_free(251);
    request_free(245);
    request_free(248);
    drain();
    live_units.delete();

    idle_pct = 25;
    repeat (380) random_item();
    drain();
    idle_pct = 78;
    repeat (380) random_item();
    drain();
    idle_pct = 0;
    repeat (370) random_item();
    drain();
    repeat (200) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
